[rtl/ntpsrb_pkg.sv]
// Shared types and constants for the NTP server response builder.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package ntpsrb_pkg;

  // one request summary
  typedef struct packed {
    logic [10:0] request_length;
    logic [7:0]  first_byte;
    logic [7:0]  poll_byte;
    logic [63:0] client_transmit;
    logic        clock_valid;
    logic [33:0] rx_unix_sec;
    logic [19:0] rx_micros;
    logic [33:0] tx_unix_sec;
    logic [19:0] tx_micros;
    logic [33:0] ref_unix_sec;
    logic [19:0] ref_micros;
  } req_t;

  // one response word
  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  word_index;
    logic        last_word;
    logic [31:0] served_total;
  } rsp_t;

  // whole response handed to the word emitter
  typedef struct packed {
    logic [11:0][31:0] words;
    logic [31:0]       served;
  } resp_buf_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CLOCK_SYNCED  = 2'd0;
  localparam logic [1:0] CFG_SOURCE_IS_PPS = 2'd1;
  localparam logic [1:0] CFG_DISPERSION_US = 2'd2;

  // request checks
  localparam logic [10:0] MIN_REQ_LEN = 11'd48;
  localparam logic [2:0]  MODE_CLIENT = 3'd3;
  localparam logic [2:0]  MODE_SERVER = 3'd4;
  localparam logic [2:0]  VER_MIN     = 3'd1;
  localparam logic [2:0]  VER_MAX     = 3'd4;

  // header fields
  localparam logic [1:0] LEAP_NONE       = 2'd0;
  localparam logic [1:0] LEAP_ALARM      = 2'd3;
  localparam logic [7:0] STRATUM_PRIMARY = 8'd1;
  localparam logic [7:0] STRATUM_UNSYNC  = 8'd16;
  localparam logic [7:0] PRECISION_BYTE  = 8'hEC;
  localparam logic [31:0] REFID_PPS      = 32'h50505300;
  localparam logic [31:0] REFID_GPS      = 32'h47505300;

  // seconds between 1900 and 1970, mod 2^32
  localparam logic [31:0] EPOCH_DELTA_SEC = 32'd2208988800;

  // ceil(2^60 / 15625): x * 2^26 / 15625 for 20-bit x is (x * RECIP) >> 34,
  // and x * 2^10 / 15625 for 36-bit x is (x * RECIP) >> 50, both exact
  localparam logic [46:0] RECIP    = 47'd73786976294839;
  localparam logic [22:0] RECIP_HI = 23'(RECIP >> 24);
  localparam logic [23:0] RECIP_LO = 24'(RECIP);

  // dispersion saturation at 65535 s
  localparam logic [35:0] DISP_SAT_US   = 36'd65535000000;
  localparam logic [31:0] DISP_SAT_WORD = 32'hFFFF0000;

  localparam logic [3:0] WORD_LAST = 4'd11;

endpackage

[rtl/ntpsrb_frac.sv]
// Microseconds to 32-bit NTP fraction: registered partial products, then sum.
// Depends on ntpsrb_pkg for the reciprocal constant.
`timescale 1ns / 1ps

module ntpsrb_frac import ntpsrb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [19:0] micros,
  output logic [31:0] frac
);

  logic [42:0] prod_hi;
  logic [43:0] prod_lo;
  logic [66:0] sum;

  // partial products against the split reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi <= 43'(micros) * 43'(RECIP_HI);
      prod_lo <= 44'(micros) * 44'(RECIP_LO);
    end
  end

  // recombine and drop the 34 fraction bits, keep low 32 of the quotient
  assign sum  = {prod_hi, 24'd0} + 67'(prod_lo);
  assign frac = sum[65:34];

endmodule

[rtl/ntpsrb_disp.sv]
// Root dispersion, microseconds to saturated 16.16 seconds.
// Depends on ntpsrb_pkg for the reciprocal and saturation constants.
`timescale 1ns / 1ps

module ntpsrb_disp import ntpsrb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [35:0] dispersion_us,
  output logic [31:0] word
);

  logic [40:0] pp_hh;
  logic [41:0] pp_hl;
  logic [40:0] pp_lh;
  logic [41:0] pp_ll;
  logic        sat;
  logic [82:0] sum;

  // four partial products of an 18/18 by 23/24 split, plus the range check
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= 41'(dispersion_us[35:18]) * 41'(RECIP_HI);
      pp_hl <= 42'(dispersion_us[35:18]) * 42'(RECIP_LO);
      pp_lh <= 41'(dispersion_us[17:0]) * 41'(RECIP_HI);
      pp_ll <= 42'(dispersion_us[17:0]) * 42'(RECIP_LO);
      sat   <= (dispersion_us >= DISP_SAT_US);
    end
  end

  // align and sum, then take the integer part
  assign sum  = (83'(pp_hh) << 42) + (83'(pp_hl) << 18)
              + (83'(pp_lh) << 24) + 83'(pp_ll);
  assign word = sat ? DISP_SAT_WORD : sum[81:50];

endmodule

[rtl/ntpsrb_emit.sv]
// Response holding register and word sequencer with a registered output.
// Depends on ntpsrb_pkg for the response and output types.
`timescale 1ns / 1ps

module ntpsrb_emit import ntpsrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      resp_valid,
  input  resp_buf_t resp,
  output logic      resp_take,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_t      rsp
);

  logic       busy;
  logic [3:0] idx;
  resp_buf_t  hold;
  logic       out_free;
  logic       send;
  logic       last;

  // handshake on the output register and the word walk
  assign out_free  = !rsp_valid || !rsp_stall;
  assign send      = busy && out_free;
  assign last      = (idx == WORD_LAST);
  assign resp_take = !busy || (send && last);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (resp_take) begin
        busy <= resp_valid;
      end
      if (send) begin
        idx <= last ? 4'd0 : idx + 4'd1;
      end
      if (out_free) begin
        rsp_valid <= send;
      end
    end
  end

  // response words, loaded whole
  always_ff @(posedge clk) begin
    if (resp_take && resp_valid) begin
      hold <= resp;
    end
  end

  // output payload per transfer
  always_ff @(posedge clk) begin
    if (send) begin
      rsp.word         <= hold.words[idx];
      rsp.word_index   <= idx;
      rsp.last_word    <= last;
      rsp.served_total <= hold.served;
    end
  end

endmodule

[rtl/ntp_server_response_builder_unit.sv]
// NTP v4 server response builder, top level.
// Depends on ntpsrb_pkg, ntpsrb_frac, ntpsrb_disp and ntpsrb_emit.
//
// Usage: a request summary is transferred on req (req_valid / req_stall).
// Requests shorter than 48 bytes, not client mode, with version outside
// 1..4 or with clock_valid low are dropped with no output and no count.
// Each answered request gives twelve 32-bit response words on rsp
// (rsp_valid / rsp_stall), word_index 0..11, last_word on word 11, and the
// served count including that request on every word.
// The first word passes the input and product stages, the emitter's holding
// register and its output register. One word per cycle while rsp_stall is
// low; the word emitter is the limit. Dropped requests leave no entry in the
// input stage. Two further requests are buffered while a response drains.
// A stall on rsp holds the current word and, once the buffers fill,
// raises req_stall. Configuration writes on cfg are always taken
// (cfg_ready high) and are meant for times when no request is in flight.
// Reset clears the configuration registers, the served count and all
// pipeline valids.
`timescale 1ns / 1ps

module ntp_server_response_builder_unit import ntpsrb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [35:0] cfg_data
);

  // configuration registers
  logic        clock_synced;
  logic        source_is_pps;
  logic [35:0] dispersion_us;

  logic [31:0] served_count;
  logic [31:0] count_next;

  // input stage
  logic        s1_valid;
  logic [2:0]  s1_ver;
  logic [7:0]  s1_poll;
  logic [63:0] s1_ctx;
  logic [31:0] s1_ref_sec;
  logic [31:0] s1_rx_sec;
  logic [31:0] s1_tx_sec;
  logic [19:0] s1_ref_us;
  logic [19:0] s1_rx_us;
  logic [19:0] s1_tx_us;
  logic [31:0] s1_count;

  // product stage
  logic        s2_valid;
  logic [2:0]  s2_ver;
  logic [7:0]  s2_poll;
  logic [63:0] s2_ctx;
  logic [31:0] s2_ref_sec;
  logic [31:0] s2_rx_sec;
  logic [31:0] s2_tx_sec;
  logic [31:0] s2_count;

  logic        keep;
  logic        req_take;
  logic        resp_take;
  logic        s2_free;
  logic        s1_free;
  logic        s2_load;
  logic [2:0]  req_ver;
  logic [2:0]  req_mode;
  logic [31:0] ref_frac;
  logic [31:0] rx_frac;
  logic [31:0] tx_frac;
  logic [31:0] disp_word;
  logic [1:0]  leap;
  logic [7:0]  stratum;
  resp_buf_t   resp;

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_synced  <= 1'b0;
      source_is_pps <= 1'b0;
      dispersion_us <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLOCK_SYNCED:  clock_synced  <= cfg_data[0];
        CFG_SOURCE_IS_PPS: source_is_pps <= cfg_data[0];
        CFG_DISPERSION_US: dispersion_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // request checks
  assign req_mode = req.first_byte[2:0];
  assign req_ver  = req.first_byte[5:3];
  assign keep     = (req.request_length >= MIN_REQ_LEN) && (req_mode == MODE_CLIENT)
                 && (req_ver >= VER_MIN) && (req_ver <= VER_MAX) && req.clock_valid;

  // pipeline flow
  assign s2_free   = !s2_valid || resp_take;
  assign s1_free   = !s1_valid || s2_free;
  assign s2_load   = s1_valid && s2_free;
  assign req_stall = !s1_free;
  assign req_take  = req_valid && !req_stall;
  assign count_next = served_count + 32'd1;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      served_count <= '0;
    end else begin
      if (s1_free) begin
        s1_valid <= req_take && keep;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (req_take && keep) begin
        served_count <= count_next;
      end
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_ver     <= req_ver;
      s1_poll    <= req.poll_byte;
      s1_ctx     <= req.client_transmit;
      s1_ref_sec <= req.ref_unix_sec[31:0];
      s1_rx_sec  <= req.rx_unix_sec[31:0];
      s1_tx_sec  <= req.tx_unix_sec[31:0];
      s1_ref_us  <= req.ref_micros;
      s1_rx_us   <= req.rx_micros;
      s1_tx_us   <= req.tx_micros;
      s1_count   <= count_next;
    end
  end

  // product stage payload
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_ver     <= s1_ver;
      s2_poll    <= s1_poll;
      s2_ctx     <= s1_ctx;
      s2_ref_sec <= s1_ref_sec;
      s2_rx_sec  <= s1_rx_sec;
      s2_tx_sec  <= s1_tx_sec;
      s2_count   <= s1_count;
    end
  end

  // fraction and dispersion converters
  ntpsrb_frac u_ref_frac (.clk(clk), .en(s2_load), .micros(s1_ref_us), .frac(ref_frac));
  ntpsrb_frac u_rx_frac  (.clk(clk), .en(s2_load), .micros(s1_rx_us),  .frac(rx_frac));
  ntpsrb_frac u_tx_frac  (.clk(clk), .en(s2_load), .micros(s1_tx_us),  .frac(tx_frac));

  ntpsrb_disp u_disp (
    .clk           (clk),
    .en            (s2_load),
    .dispersion_us (dispersion_us),
    .word          (disp_word)
  );

  // response assembly
  assign leap    = clock_synced ? LEAP_NONE : LEAP_ALARM;
  assign stratum = clock_synced ? STRATUM_PRIMARY : STRATUM_UNSYNC;

  always_comb begin
    resp.words[0]  = {leap, s2_ver, MODE_SERVER, stratum, s2_poll, PRECISION_BYTE};
    resp.words[1]  = 32'd0;
    resp.words[2]  = disp_word;
    resp.words[3]  = source_is_pps ? REFID_PPS : REFID_GPS;
    resp.words[4]  = s2_ref_sec + EPOCH_DELTA_SEC;
    resp.words[5]  = ref_frac;
    resp.words[6]  = s2_ctx[63:32];
    resp.words[7]  = s2_ctx[31:0];
    resp.words[8]  = s2_rx_sec + EPOCH_DELTA_SEC;
    resp.words[9]  = rx_frac;
    resp.words[10] = s2_tx_sec + EPOCH_DELTA_SEC;
    resp.words[11] = tx_frac;
    resp.served    = s2_count;
  end

  // word emitter
  ntpsrb_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .resp_valid (s2_valid),
    .resp       (resp),
    .resp_take  (resp_take),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

[verif/ntp_server_response_builder_unit_tb.sv]
// Self-checking testbench for the NTP server response builder: directed request checks,
// register settings, random traffic and a long response stall, all against a predictor.
// Depends on ntpsrb_pkg and ntp_server_response_builder_unit.
`timescale 1ns / 1ps

module ntp_server_response_builder_unit_tb;
  import ntpsrb_pkg::*;

  // request acceptance and header constants of the predictor
  localparam logic [10:0] MIN_LEN = 11'd48;
  localparam logic [2:0] MODE_REQ = 3'd3;
  localparam logic [2:0] MODE_REPLY = 3'd4;
  localparam logic [2:0] VERSION_LOW = 3'd1;
  localparam logic [2:0] VERSION_HIGH = 3'd4;
  localparam logic [1:0] NO_LEAP = 2'd0;
  localparam logic [1:0] ALARM_LEAP = 2'd3;
  localparam logic [7:0] STRATUM_SYNCED = 8'd1;
  localparam logic [7:0] STRATUM_FREE = 8'd16;
  localparam logic [7:0] PRECISION = 8'hEC;
  localparam logic [31:0] PPS_ID = 32'h50505300;
  localparam logic [31:0] GPS_ID = 32'h47505300;
  localparam logic [63:0] UNIX_TO_NTP = 64'd2208988800;
  localparam logic [63:0] US_PER_SEC = 64'd1000000;
  localparam logic [35:0] DISP_LIMIT_US = 36'd65535000000;
  localparam logic [31:0] DISP_CEILING = 32'hFFFF0000;
  localparam int LAST_INDEX = 11;

  // index with no register behind it
  localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

  // run control
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 8;
  // longest quiet stretch of a correct run is the long hold plus a settle pause
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 30;
  localparam int ANSWERS_PER_PHASE = 70;

  typedef enum {ITEM_GOOD, ITEM_FAULTY, ITEM_NOISE} item_kind_t;
  typedef enum {FAULT_SHORT, FAULT_MODE, FAULT_VERSION, FAULT_CLOCK} fault_kind_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [35:0] cfg_data;

  // predictor state
  logic synced_cfg = 1'b0;
  logic pps_cfg = 1'b0;
  logic [35:0] dispersion_cfg = '0;
  logic [31:0] served_count = '0;
  rsp_t expected_words[$];

  int mismatch_count = 0;
  bit no_idle = 1'b0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  ntp_server_response_builder_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly none, some short, a few long
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [31:0] ntp_seconds_word(logic [33:0] unix_sec);
    logic [63:0] sum;
    sum = 64'(unix_sec) + UNIX_TO_NTP;
    return sum[31:0];
  endfunction

  function automatic logic [31:0] ntp_fraction_word(logic [19:0] micros);
    logic [63:0] scaled;
    scaled = (64'(micros) << 32) / US_PER_SEC;
    return scaled[31:0];
  endfunction

  // microseconds to 16.16 seconds, saturating at 65535 s
  function automatic logic [31:0] dispersion_word(logic [35:0] us);
    logic [63:0] scaled;
    if (us >= DISP_LIMIT_US) return DISP_CEILING;
    scaled = (64'(us) << 16) / US_PER_SEC;
    return scaled[31:0];
  endfunction

  // queue the twelve reply words of an answered request
  function automatic void predict_response(req_t r);
    logic [2:0] mode;
    logic [2:0] ver;
    logic [31:0] words [12];
    rsp_t item;
    mode = r.first_byte[2:0];
    ver = r.first_byte[5:3];
    if (r.request_length < MIN_LEN || mode != MODE_REQ || ver < VERSION_LOW ||
        ver > VERSION_HIGH || !r.clock_valid) return;
    served_count = served_count + 32'd1;
    words[0] = {synced_cfg ? NO_LEAP : ALARM_LEAP, ver, MODE_REPLY,
                synced_cfg ? STRATUM_SYNCED : STRATUM_FREE, r.poll_byte, PRECISION};
    words[1] = '0;
    words[2] = dispersion_word(dispersion_cfg);
    words[3] = pps_cfg ? PPS_ID : GPS_ID;
    words[4] = ntp_seconds_word(r.ref_unix_sec);
    words[5] = ntp_fraction_word(r.ref_micros);
    words[6] = r.client_transmit[63:32];
    words[7] = r.client_transmit[31:0];
    words[8] = ntp_seconds_word(r.rx_unix_sec);
    words[9] = ntp_fraction_word(r.rx_micros);
    words[10] = ntp_seconds_word(r.tx_unix_sec);
    words[11] = ntp_fraction_word(r.tx_micros);
    for (int k = 0; k < 12; k++) begin
      item.word = words[k];
      item.word_index = 4'(k);
      item.last_word = (k == LAST_INDEX);
      item.served_total = served_count;
      expected_words.push_back(item);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // compare one response transfer with the oldest expected word
  task automatic check_response_word(rsp_t got);
    rsp_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with no answer pending", got.word, '0);
    end else begin
      want = expected_words.pop_front();
      if (got.word !== want.word) report_mismatch("word", got.word, want.word);
      if (got.word_index !== want.word_index)
        report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
      if (got.last_word !== want.last_word)
        report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
      if (got.served_total !== want.served_total)
        report_mismatch("served_total", got.served_total, want.served_total);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) check_response_word(rsp);
  end

  // receiver: random stalls, plus a long hold whenever one is asked for
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else begin
      stall_left = no_idle ? 0 : idle_gap();
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // watchdog on cycles with no transfer on any channel
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [19:0] random_micros();
    if ($urandom_range(0, 9) == 0) return 20'($urandom);
    return 20'($urandom_range(0, 999999));
  endfunction

  function automatic req_t plain_request(logic [2:0] ver, logic [2:0] mode);
    req_t r;
    r = '0;
    r.request_length = MIN_LEN;
    r.first_byte = {2'b00, ver, mode};
    r.poll_byte = 8'd6;
    r.clock_valid = 1'b1;
    return r;
  endfunction

  // well-formed request, one with a single fault, or raw noise
  function automatic req_t random_request(item_kind_t kind);
    req_t r;
    logic [2:0] ver;
    logic [2:0] mode;
    r.request_length = ($urandom_range(0, 3) == 0) ? MIN_LEN :
                       11'($urandom_range(MIN_LEN, 2047));
    ver = 3'($urandom_range(VERSION_LOW, VERSION_HIGH));
    mode = MODE_REQ;
    r.poll_byte = 8'($urandom);
    r.client_transmit = {$urandom, $urandom};
    r.clock_valid = 1'b1;
    r.rx_unix_sec = 34'({$urandom, $urandom});
    r.tx_unix_sec = 34'({$urandom, $urandom});
    r.ref_unix_sec = 34'({$urandom, $urandom});
    r.rx_micros = random_micros();
    r.tx_micros = random_micros();
    r.ref_micros = random_micros();
    if (kind == ITEM_FAULTY) begin
      case (fault_kind_t'($urandom_range(0, 3)))
        FAULT_SHORT: r.request_length = 11'($urandom_range(0, MIN_LEN - 1));
        // any mode but client, wrapping around
        FAULT_MODE: mode = 3'(MODE_REQ + $urandom_range(1, 7));
        // 5, 6, 7 or 0
        FAULT_VERSION: ver = 3'(VERSION_HIGH + $urandom_range(1, 4));
        FAULT_CLOCK: r.clock_valid = 1'b0;
      endcase
    end
    r.first_byte = {2'($urandom), ver, mode};
    if (kind == ITEM_NOISE) begin
      r.request_length = 11'($urandom);
      r.first_byte = 8'($urandom);
      r.clock_valid = 1'($urandom);
    end
    return r;
  endfunction

  // one request transfer; valid stays up after it until the next call or a drain
  task automatic send_request(req_t r);
    int gap;
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    predict_response(r);
  endtask

  task automatic send_burst(int count);
    for (int i = 0; i < count; i++) send_request(random_request(ITEM_GOOD));
  endtask

  // stop offering, wait for every expected word, then let dropped requests settle
  task automatic wait_for_drain();
    if (req_valid) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [35:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (index)
      CFG_CLOCK_SYNCED: synced_cfg = value[0];
      CFG_SOURCE_IS_PPS: pps_cfg = value[0];
      CFG_DISPERSION_US: dispersion_cfg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // single-bit registers get random upper data bits
  task automatic apply_setting(bit synced, bit pps, logic [35:0] disp);
    wait_for_drain();
    write_register(CFG_CLOCK_SYNCED, {3'($urandom), 32'($urandom), synced});
    write_register(CFG_SOURCE_IS_PPS, {3'($urandom), 32'($urandom), pps});
    write_register(CFG_DISPERSION_US, disp);
  endtask

  // directed request checks under reset register values
  task automatic test_request_checks();
    req_t r;
    // shortest accepted request, zero times
    r = plain_request(VERSION_HIGH, MODE_REQ);
    send_request(r);
    // one byte short, then empty
    r.request_length = MIN_LEN - 1;
    send_request(r);
    r.request_length = '0;
    send_request(r);
    // every field at its top
    r = '1;
    r.first_byte = {2'b11, VERSION_LOW, MODE_REQ};
    send_request(r);
    // every mode other than client
    for (int m = 0; m < 8; m++) begin
      if (3'(m) != MODE_REQ) send_request(plain_request(VERSION_HIGH, 3'(m)));
    end
    // remaining versions, out of range and in range
    for (int v = 0; v < 8; v++) begin
      if (3'(v) != VERSION_LOW && 3'(v) != VERSION_HIGH)
        send_request(plain_request(3'(v), MODE_REQ));
    end
    // clock not valid
    r = plain_request(VERSION_HIGH, MODE_REQ);
    r.clock_valid = 1'b0;
    send_request(r);
    // micros at the end of range and past it
    r = plain_request(3'd3, MODE_REQ);
    r.rx_micros = 20'd999999;
    r.tx_micros = 20'd1000000;
    r.ref_micros = '1;
    r.client_transmit = 64'h0123456789ABCDEF;
    send_request(r);
    // seconds either side of the ntp era wrap
    r = plain_request(VERSION_HIGH, MODE_REQ);
    r.rx_unix_sec = 34'd2085978495;
    r.tx_unix_sec = 34'd2085978496;
    r.ref_unix_sec = 34'h200000000;
    send_request(r);
    wait_for_drain();
  endtask

  // register settings including the dispersion extremes
  task automatic test_config_registers();
    apply_setting(1'b1, 1'b1, '0);
    send_burst(3);
    apply_setting(1'b1, 1'b1, DISP_LIMIT_US - 1);
    send_burst(3);
    apply_setting(1'b0, 1'b1, DISP_LIMIT_US);
    send_burst(3);
    apply_setting(1'b1, 1'b0, '1);
    send_burst(3);
    apply_setting(1'b0, 1'b0, 36'd1);
    send_burst(3);
    // a write to the unused index changes nothing
    wait_for_drain();
    write_register(CFG_SPARE_INDEX, '1);
    send_burst(3);
  endtask

  // random traffic in phases, each under its own register setting
  task automatic test_random_traffic();
    logic [31:0] phase_start;
    int roll;
    item_kind_t kind;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: apply_setting(1'b0, 1'b0, 36'({$urandom, $urandom}));
        1: apply_setting(1'b1, 1'b1, 36'({$urandom, $urandom} % DISP_LIMIT_US));
        2: apply_setting(1'b1, 1'b0, 36'($urandom_range(0, 2000000)));
        default: apply_setting(1'($urandom), 1'($urandom), 36'({$urandom, $urandom}));
      endcase
      // one phase runs with no idling on either side
      no_idle = (phase == 2);
      phase_start = served_count;
      while (served_count - phase_start < ANSWERS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) kind = ITEM_GOOD;
        else if (roll < 90) kind = ITEM_FAULTY;
        else kind = ITEM_NOISE;
        send_request(random_request(kind));
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the block fills and stalls
  task automatic test_backpressure();
    wait_for_drain();
    holds_asked++;
    no_idle = 1'b1;
    send_burst(16);
    no_idle = 1'b0;
    wait_for_drain();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_request_checks();
    test_config_registers();
    test_random_traffic();
    test_backpressure();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[ntp_server_response_builder_unit.f]
rtl/ntpsrb_pkg.sv
rtl/ntpsrb_frac.sv
rtl/ntpsrb_disp.sv
rtl/ntpsrb_emit.sv
rtl/ntp_server_response_builder_unit.sv
verif/ntp_server_response_builder_unit_tb.sv
